[rtl/core/dpq_pkg.sv]
// ----------------------------------------------------------------------------
// dpq_pkg
// Shared types and constants for the double-ended pair queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

   localparam int DPQ_DEPTH = 64;
   localparam int DATA_W    = 32;
   localparam int OPC_W     = 3;
   localparam int STAT_W    = 2;
   localparam int CNT_W     = 7;

   typedef enum logic [OPC_W-1:0] {
      OPC_PUSH_FRONT = 3'd0,
      OPC_PUSH_BACK  = 3'd1,
      OPC_POP_FRONT  = 3'd2,
      OPC_POP_BACK   = 3'd3,
      OPC_CLEAR      = 3'd4,
      OPC_DUMP_FWD   = 3'd5,
      OPC_DUMP_BWD   = 3'd6
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_DATA  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic                     clear;
      logic                     dump;
      logic                     at_back;
      logic signed [DATA_W-1:0] first_value;
      logic signed [DATA_W-1:0] second_value;
   } dpq_cmd_type;

   typedef struct packed {
      logic             dumping;
      logic [CNT_W-1:0] count;
   } dpq_stat_type;

endpackage

[rtl/core/dpq_req_if.sv]
// ----------------------------------------------------------------------------
// dpq_req_if
// Request channel: one queue operation per beat.
// ----------------------------------------------------------------------------
interface dpq_req_if import dpq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OPC_W-1:0]         opcode;
   logic signed [DATA_W-1:0] first_value;
   logic signed [DATA_W-1:0] second_value;

   modport source (output valid, opcode, first_value, second_value, input ready);
   modport sink   (input valid, opcode, first_value, second_value, output ready);
endinterface

[rtl/core/dpq_rsp_if.sv]
// ----------------------------------------------------------------------------
// dpq_rsp_if
// Response channel: one dumped pair or status per beat.
// ----------------------------------------------------------------------------
interface dpq_rsp_if import dpq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_first;
   logic signed [DATA_W-1:0] out_second;
   logic [STAT_W-1:0]        status;
   logic                     last_item;

   modport source (output valid, out_first, out_second, status, last_item, input ready);
   modport sink   (input valid, out_first, out_second, status, last_item, output ready);
endinterface

[rtl/core/dpq_front.sv]
// ----------------------------------------------------------------------------
// dpq_front
// Accepts request beats, decodes the opcode and buffers commands in a
// two-entry queue ahead of the execution side.
// ----------------------------------------------------------------------------
module dpq_front import dpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dpq_req_if.sink     req,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output dpq_cmd_type cmd
);

   dpq_cmd_type decoded;
   dpq_cmd_type queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        take, give;

   always_comb begin
      decoded              = '0;
      decoded.first_value  = req.first_value;
      decoded.second_value = req.second_value;
      unique case (req.opcode)
         OPC_PUSH_FRONT: decoded.push = 1'b1;
         OPC_PUSH_BACK: begin
            decoded.push    = 1'b1;
            decoded.at_back = 1'b1;
         end
         OPC_POP_FRONT: decoded.pop = 1'b1;
         OPC_POP_BACK: begin
            decoded.pop     = 1'b1;
            decoded.at_back = 1'b1;
         end
         OPC_CLEAR: decoded.clear = 1'b1;
         OPC_DUMP_FWD: decoded.dump = 1'b1;
         OPC_DUMP_BWD: begin
            decoded.dump    = 1'b1;
            decoded.at_back = 1'b1;
         end
         default: ;
      endcase
   end

   assign req.ready = (fill_ff != 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign take      = req.valid && req.ready;
   assign give      = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ take;
      rd_ptr_in = rd_ptr_ff ^ give;
      fill_in   = fill_ff + 2'(take) - 2'(give);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[rtl/core/dpq_back.sv]
// ----------------------------------------------------------------------------
// dpq_back
// Executes queue commands on the ring store and streams dump results
// through a read stage and an output register.
// ----------------------------------------------------------------------------
module dpq_back import dpq_pkg::*; #(
   parameter int DEPTH = DPQ_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  dpq_cmd_type  cmd,
   dpq_rsp_if.source    rsp,
   output dpq_stat_type stat
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = IW + 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } back_state_type;

   function automatic logic [IW-1:0] ring_wrap(input logic [SW-1:0] sum);
      if (sum >= SW'(DEPTH)) begin
         return IW'(sum - SW'(DEPTH));
      end
      return IW'(sum);
   endfunction

   logic [DATA_W-1:0] first_mem  [DEPTH];
   logic [DATA_W-1:0] second_mem [DEPTH];

   back_state_type    state_ff, state_in;
   logic [IW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              dir_back_ff, dir_back_in;

   logic              s1_valid_ff, s1_valid_in;
   status_type        s1_status_ff, s1_status_in;
   logic              s1_last_ff, s1_last_in;
   logic [DATA_W-1:0] rd_first_ff, rd_second_ff;

   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff;
   logic              out_last_ff;
   logic [DATA_W-1:0] out_first_ff, out_second_ff;

   logic              full, empty, s2_free, s1_free, s1_move;
   logic              rd_en, wr_en, dump_last;
   logic [IW-1:0]     rd_addr, wr_addr;
   logic [CW-1:0]     offset;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign s2_free   = !out_valid_ff || rsp.ready;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign cmd_ready = (state_ff == ST_IDLE) && s1_free;
   assign rd_en     = (state_ff == ST_DUMP) && s1_free;
   assign dump_last = (idx_ff == count_ff - 1'b1);
   assign offset    = dir_back_ff ? (count_ff - 1'b1 - idx_ff) : idx_ff;
   assign rd_addr   = ring_wrap(SW'(head_ff) + SW'(offset));

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      dir_back_in  = dir_back_ff;
      s1_valid_in  = s1_valid_ff && !s1_move;
      s1_status_in = s1_status_ff;
      s1_last_in   = s1_last_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;

      if (cmd_valid && cmd_ready) begin
         if (cmd.push) begin
            if (full) begin
               s1_valid_in  = 1'b1;
               s1_status_in = STATUS_FULL;
               s1_last_in   = 1'b1;
            end else if (cmd.at_back) begin
               wr_en    = 1'b1;
               wr_addr  = ring_wrap(SW'(head_ff) + SW'(count_ff));
               count_in = count_ff + 1'b1;
            end else begin
               head_in  = (head_ff == '0) ? IW'(DEPTH - 1) : head_ff - 1'b1;
               wr_en    = 1'b1;
               wr_addr  = head_in;
               count_in = count_ff + 1'b1;
            end
         end else if (cmd.pop) begin
            if (!empty) begin
               count_in = count_ff - 1'b1;
               if (!cmd.at_back) begin
                  head_in = ring_wrap(SW'(head_ff) + SW'(1));
               end
            end
         end else if (cmd.clear) begin
            head_in  = '0;
            count_in = '0;
         end else if (cmd.dump) begin
            if (empty) begin
               s1_valid_in  = 1'b1;
               s1_status_in = STATUS_EMPTY;
               s1_last_in   = 1'b1;
            end else begin
               state_in    = ST_DUMP;
               idx_in      = '0;
               dir_back_in = cmd.at_back;
            end
         end
      end

      // one stored pair per beat while dumping
      if (rd_en) begin
         s1_valid_in  = 1'b1;
         s1_status_in = STATUS_DATA;
         s1_last_in   = dump_last;
         idx_in       = idx_ff + 1'b1;
         if (dump_last) begin
            state_in = ST_IDLE;
         end
      end

      out_valid_in = s1_move ? 1'b1 : (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         dir_back_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         dir_back_ff  <= dir_back_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         first_mem[wr_addr]  <= cmd.first_value;
         second_mem[wr_addr] <= cmd.second_value;
      end
      if (rd_en) begin
         rd_first_ff  <= first_mem[rd_addr];
         rd_second_ff <= second_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= s1_status_in;
      s1_last_ff   <= s1_last_in;
      if (s1_move) begin
         out_status_ff <= s1_status_ff;
         out_last_ff   <= s1_last_ff;
         out_first_ff  <= (s1_status_ff == STATUS_DATA) ? rd_first_ff : '0;
         out_second_ff <= (s1_status_ff == STATUS_DATA) ? rd_second_ff : '0;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.out_first  = out_first_ff;
   assign rsp.out_second = out_second_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.last_item  = out_last_ff;

   assign stat.dumping = (state_ff == ST_DUMP);
   assign stat.count   = CNT_W'(count_ff);

endmodule

[rtl/core/double_ended_pair_queue_core.sv]
// ----------------------------------------------------------------------------
// double_ended_pair_queue_core
// Double-ended queue of 32-bit pairs in a ring store with head and count.
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          opcode, first_value, second_value
//   rsp_chan  out  valid/ready          out_first, out_second, status, last_item
//
// Push, pop and clear complete in the execution stage. A dump emits its pairs
// one pair per cycle unless the response side stalls, limited by the single
// store read port; each pair passes the read stage and the output register.
// Synchronous reset empties the queue; store contents are not cleared.
// A two-entry command queue keeps requests flowing while the response
// side stalls; a stalled response holds the execution stage.
// ----------------------------------------------------------------------------
module double_ended_pair_queue_core import dpq_pkg::*; #(
   parameter int DEPTH = DPQ_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   dpq_req_if.sink    req_chan,
   dpq_rsp_if.source  rsp_chan
);

   logic         cmd_valid;
   logic         cmd_ready;
   dpq_cmd_type  cmd;
   dpq_stat_type stat;

   dpq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   dpq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp       (rsp_chan),
      .stat      (stat)
   );

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_dump_nonempty : assert property (@(posedge clock) disable iff (reset)
      stat.dumping |-> stat.count != '0)
      else $error("dump running on empty queue");

   a_no_cmd_in_dump : assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ready |-> !stat.dumping)
      else $error("command taken during dump");

   a_status_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != STATUS_DATA |->
         rsp_chan.last_item && rsp_chan.out_first == '0 && rsp_chan.out_second == '0)
      else $error("status beat malformed");

endmodule

[tb/tb_double_ended_pair_queue_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_pair_queue_core
// Self-checking bench for the double-ended pair queue. A shadow deque tracks
// head and count on every accepted request beat and queues the dump, empty
// and overflow beats it implies; each response beat is compared against the
// oldest queued beat. Covers directed corner cases, fill and overflow with
// ring wrap, random traffic, and a long response hold-off.
// ----------------------------------------------------------------------------
module tb_double_ended_pair_queue_core;
   import dpq_pkg::*;

   localparam int               IDX_W       = $clog2(DPQ_DEPTH);
   localparam logic [OPC_W-1:0] OPC_UNUSED  = 3'd7;
   localparam int               DRAIN_CYCLES = 16;
   localparam int               MAX_REPORTS  = 10;

   typedef struct {
      logic signed [DATA_W-1:0] first_value;
      logic signed [DATA_W-1:0] second_value;
      status_type               status;
      logic                     last_item;
   } pair_beat_type;

   logic clock;
   logic reset;
   bit   idle_on;
   int   hold_off_len;
   int   mismatch_count;

   logic signed [DATA_W-1:0] shadow_first[DPQ_DEPTH];
   logic signed [DATA_W-1:0] shadow_second[DPQ_DEPTH];
   logic [IDX_W-1:0]         shadow_head;
   logic [CNT_W-1:0]         shadow_count;
   pair_beat_type            pending_beats[$];

   dpq_req_if req_bus ();
   dpq_rsp_if rsp_bus ();

   double_ended_pair_queue_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("tb_double_ended_pair_queue_core: FAIL");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 11))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void queue_beat(logic signed [DATA_W-1:0] a,
                                      logic signed [DATA_W-1:0] b,
                                      status_type st, logic last);
      pair_beat_type beat;
      beat.first_value  = a;
      beat.second_value = b;
      beat.status       = st;
      beat.last_item    = last;
      pending_beats.push_back(beat);
   endfunction

   // shadow deque: update state and queue the beats this request produces
   function automatic void apply_queue_op(logic [OPC_W-1:0] opc,
                                          logic signed [DATA_W-1:0] a,
                                          logic signed [DATA_W-1:0] b);
      int pos;
      int off;
      case (opc) inside
         OPC_PUSH_FRONT, OPC_PUSH_BACK: begin
            if (shadow_count >= DPQ_DEPTH) begin
               queue_beat('0, '0, STATUS_FULL, 1'b1);
            end else begin
               if (opc == OPC_PUSH_FRONT) begin
                  shadow_head = IDX_W'((int'(shadow_head) + DPQ_DEPTH - 1) % DPQ_DEPTH);
                  pos = int'(shadow_head);
               end else begin
                  pos = (int'(shadow_head) + int'(shadow_count)) % DPQ_DEPTH;
               end
               shadow_first[pos]  = a;
               shadow_second[pos] = b;
               shadow_count       = shadow_count + 1'b1;
            end
         end
         OPC_POP_FRONT: begin
            if (shadow_count != 0) begin
               shadow_head  = IDX_W'((int'(shadow_head) + 1) % DPQ_DEPTH);
               shadow_count = shadow_count - 1'b1;
            end
         end
         OPC_POP_BACK: begin
            if (shadow_count != 0) shadow_count = shadow_count - 1'b1;
         end
         OPC_CLEAR: begin
            shadow_head  = '0;
            shadow_count = '0;
         end
         OPC_DUMP_FWD, OPC_DUMP_BWD: begin
            if (shadow_count == 0) begin
               queue_beat('0, '0, STATUS_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < int'(shadow_count); i++) begin
                  off = (opc == OPC_DUMP_FWD) ? i : int'(shadow_count) - 1 - i;
                  pos = (int'(shadow_head) + off) % DPQ_DEPTH;
                  queue_beat(shadow_first[pos], shadow_second[pos], STATUS_DATA,
                             i + 1 == int'(shadow_count));
               end
            end
         end
         default: ;
      endcase
   endfunction

   // response check first, then request prediction (responses are registered behind the request)
   always @(posedge clock) begin
      pair_beat_type exp_beat;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_beats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected beat first=%0d second=%0d status=%0d last=%0b",
                           $realtime, rsp_bus.out_first, rsp_bus.out_second,
                           rsp_bus.status, rsp_bus.last_item);
            end else begin
               exp_beat = pending_beats.pop_front();
               if (rsp_bus.out_first !== exp_beat.first_value ||
                   rsp_bus.out_second !== exp_beat.second_value ||
                   rsp_bus.status !== exp_beat.status ||
                   rsp_bus.last_item !== exp_beat.last_item) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: mismatch exp first=%0d second=%0d status=%0d last=%0b",
                              $realtime, exp_beat.first_value, exp_beat.second_value,
                              exp_beat.status, exp_beat.last_item);
                     $display("%0t:          got first=%0d second=%0d status=%0d last=%0b",
                              $realtime, rsp_bus.out_first, rsp_bus.out_second,
                              rsp_bus.status, rsp_bus.last_item);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            apply_queue_op(req_bus.opcode, req_bus.first_value, req_bus.second_value);
      end
   end

   // response ready: random stalls, plus a long hold-off on request
   initial begin : rsp_ready_drive
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_len > 0) begin
            n            = hold_off_len;
            hold_off_len = 0;
         end else begin
            n = idle_on ? gap_len() : 0;
         end
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_op(input logic [OPC_W-1:0] opc, input logic [DATA_W-1:0] a,
                          input logic [DATA_W-1:0] b);
      int gap;
      gap = idle_on ? gap_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= opc;
      req_bus.first_value  <= a;
      req_bus.second_value <= b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_rand_push(input logic [OPC_W-1:0] opc);
      send_op(opc, rand_word(), rand_word());
   endtask

   task automatic end_phase();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(OPC_DUMP_FWD, '0, '0);
      send_op(OPC_DUMP_BWD, '1, '1);
      send_op(OPC_POP_FRONT, '0, '0);
      send_op(OPC_POP_BACK, '0, '0);
      send_op(OPC_PUSH_BACK, 32'h7FFF_FFFF, 32'h8000_0000);
      send_op(OPC_PUSH_FRONT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_op(OPC_PUSH_BACK, 32'h0000_0000, 32'hFFFF_FFFF);
      send_op(OPC_PUSH_FRONT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_op(OPC_DUMP_FWD, '0, '0);
      send_op(OPC_DUMP_BWD, '0, '0);
      send_op(OPC_UNUSED, rand_word(), rand_word());
      send_op(OPC_DUMP_FWD, '0, '0);
      send_op(OPC_POP_FRONT, '0, '0);
      send_op(OPC_POP_BACK, '0, '0);
      send_op(OPC_DUMP_BWD, '0, '0);
      send_op(OPC_CLEAR, '0, '0);
      send_op(OPC_DUMP_FWD, '0, '0);
      send_op(OPC_PUSH_FRONT, 32'h5555_5555, 32'hAAAA_AAAA);
      send_op(OPC_DUMP_BWD, '0, '0);
      send_op(OPC_CLEAR, '0, '0);
      end_phase();
   endtask

   // fill to capacity, overflow at both ends, then wrap the ring
   task automatic test_fill_and_overflow();
      send_op(OPC_CLEAR, '0, '0);
      repeat (DPQ_DEPTH)
         send_rand_push($urandom_range(0, 1) ? OPC_PUSH_FRONT : OPC_PUSH_BACK);
      send_rand_push(OPC_PUSH_FRONT);
      send_rand_push(OPC_PUSH_BACK);
      send_op(OPC_DUMP_FWD, '0, '0);
      send_op(OPC_DUMP_BWD, '0, '0);
      repeat (3) send_op(OPC_POP_FRONT, '0, '0);
      repeat (3) send_rand_push(OPC_PUSH_BACK);
      send_rand_push(OPC_PUSH_FRONT);
      repeat (2) send_op(OPC_POP_BACK, '0, '0);
      send_op(OPC_DUMP_FWD, '0, '0);
      end_phase();
   endtask

   task automatic test_random_traffic();
      int r;
      logic [OPC_W-1:0] opc;
      repeat (53) begin
         r = $urandom_range(0, 99);
         if      (r < 25) opc = OPC_PUSH_FRONT;
         else if (r < 50) opc = OPC_PUSH_BACK;
         else if (r < 62) opc = OPC_POP_FRONT;
         else if (r < 74) opc = OPC_POP_BACK;
         else if (r < 77) opc = OPC_CLEAR;
         else if (r < 86) opc = OPC_DUMP_FWD;
         else if (r < 95) opc = OPC_DUMP_BWD;
         else             opc = OPC_UNUSED;
         send_op(opc, rand_word(), rand_word());
      end
      end_phase();
   endtask

   // response side held off while dumps keep coming, so the input backs up
   task automatic test_backpressure();
      send_op(OPC_CLEAR, '0, '0);
      repeat (5) send_rand_push(OPC_PUSH_BACK);
      hold_off_len = 300;
      repeat (5) begin
         send_op(OPC_DUMP_FWD, '0, '0);
         send_op(OPC_DUMP_BWD, '0, '0);
      end
      send_rand_push(OPC_PUSH_FRONT);
      send_op(OPC_DUMP_FWD, '0, '0);
      end_phase();
   endtask

   initial begin
      reset                = 1'b1;
      idle_on              = 1'b0;
      hold_off_len         = 0;
      mismatch_count       = 0;
      shadow_head          = '0;
      shadow_count         = '0;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OPC_PUSH_FRONT;
      req_bus.first_value  = '0;
      req_bus.second_value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      idle_on = 1'b1;
      test_fill_and_overflow();
      test_random_traffic();
      test_backpressure();
      if (mismatch_count == 0 && pending_beats.size() == 0)
         $display("tb_double_ended_pair_queue_core: PASS");
      else
         $display("tb_double_ended_pair_queue_core: FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/core/dpq_pkg.sv
rtl/core/dpq_req_if.sv
rtl/core/dpq_rsp_if.sv
rtl/core/dpq_front.sv
rtl/core/dpq_back.sv
rtl/core/double_ended_pair_queue_core.sv
tb/tb_double_ended_pair_queue_core.sv
